FILE: rtl/core/qrv_pkg.sv
// Types and widths shared by the quaternion rotation pipeline.
// Used by every file in rtl/core; depends on nothing.
package qrv_pkg;

  localparam int QuatW = 16;
  localparam int VecW  = 16;
  // q*v partial products and their sums
  localparam int Mul1W = QuatW + VecW;
  localparam int PW    = Mul1W + 2;
  // p*conj(q) partial products and their sums
  localparam int Mul2W = PW + QuatW;
  localparam int RW    = Mul2W + 2;

  typedef struct packed {
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
    logic signed [QuatW-1:0] quat_w;
    logic signed [VecW-1:0]  vec_x;
    logic signed [VecW-1:0]  vec_y;
    logic signed [VecW-1:0]  vec_z;
  } in_t;

  typedef struct packed {
    logic signed [VecW-1:0] rot_x;
    logic signed [VecW-1:0] rot_y;
    logic signed [VecW-1:0] rot_z;
    logic                   saturated;
  } out_t;

  typedef struct packed {
    logic signed [QuatW-1:0] x;
    logic signed [QuatW-1:0] y;
    logic signed [QuatW-1:0] z;
    logic signed [QuatW-1:0] w;
  } quat_t;

  // first Hamilton product q*(v,0), carried with q
  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] pz;
    logic signed [PW-1:0] pw;
    quat_t                q;
  } qv_t;

  // vector part of p*conj(q), unscaled
  typedef struct packed {
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] ry;
    logic signed [RW-1:0] rz;
  } res_t;

endpackage

FILE: rtl/core/qrv_skid.sv
// Input skid buffer: registered stall toward the sender.
// Depends on qrv_pkg.
module qrv_skid (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  qrv_pkg::in_t in_data_i,
  input  logic         adv_i,
  output logic         valid_o,
  output qrv_pkg::in_t data_o,
  output logic         full_o
);

  logic         skid_v_q, skid_v_d;
  qrv_pkg::in_t skid_q;

  assign in_stall_o = skid_v_q;
  assign full_o     = skid_v_q;
  assign valid_o    = skid_v_q | in_valid_i;
  assign data_o     = skid_v_q ? skid_q : in_data_i;

  always_comb begin
    skid_v_d = skid_v_q;
    if (adv_i) begin
      skid_v_d = 1'b0;
    end else if (in_valid_i && !skid_v_q) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv_i && in_valid_i && !skid_v_q) begin
      skid_q <= in_data_i;
    end
  end

endmodule

FILE: rtl/core/qrv_qv_mul.sv
// First Hamilton product p = q * (v, 0): multiply stage, then sum stage.
// Depends on qrv_pkg.
module qrv_qv_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  qrv_pkg::in_t data_i,
  output logic         valid_o,
  output qrv_pkg::qv_t data_o
);

  localparam int MW = qrv_pkg::Mul1W;
  localparam int PW = qrv_pkg::PW;

  logic signed [qrv_pkg::QuatW-1:0] x, y, z, w;
  logic signed [qrv_pkg::VecW-1:0]  vx, vy, vz;
  logic signed [MW-1:0] m_d [12];
  logic signed [MW-1:0] m_q [12];
  qrv_pkg::quat_t       q1_q;
  logic                 v1_q, v2_q;
  qrv_pkg::qv_t         p_d, p_q;

  assign x  = data_i.quat_x;
  assign y  = data_i.quat_y;
  assign z  = data_i.quat_z;
  assign w  = data_i.quat_w;
  assign vx = data_i.vec_x;
  assign vy = data_i.vec_y;
  assign vz = data_i.vec_z;

  always_comb begin
    m_d[0]  = MW'(w * vx);
    m_d[1]  = MW'(y * vz);
    m_d[2]  = MW'(z * vy);
    m_d[3]  = MW'(w * vy);
    m_d[4]  = MW'(x * vz);
    m_d[5]  = MW'(z * vx);
    m_d[6]  = MW'(w * vz);
    m_d[7]  = MW'(x * vy);
    m_d[8]  = MW'(y * vx);
    m_d[9]  = MW'(x * vx);
    m_d[10] = MW'(y * vy);
    m_d[11] = MW'(z * vz);
  end

  always_comb begin
    p_d.px = PW'(m_q[0]) + PW'(m_q[1]) - PW'(m_q[2]);
    p_d.py = PW'(m_q[3]) - PW'(m_q[4]) + PW'(m_q[5]);
    p_d.pz = PW'(m_q[6]) + PW'(m_q[7]) - PW'(m_q[8]);
    p_d.pw = -PW'(m_q[9]) - PW'(m_q[10]) - PW'(m_q[11]);
    p_d.q  = q1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      q1_q.x <= x;
      q1_q.y <= y;
      q1_q.z <= z;
      q1_q.w <= w;
      p_q    <= p_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = p_q;

endmodule

FILE: rtl/core/qrv_pq_mul.sv
// Second Hamilton product p * conj(q), vector part: multiply stage, then sum stage.
// Depends on qrv_pkg.
module qrv_pq_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qrv_pkg::qv_t  data_i,
  output logic          valid_o,
  output qrv_pkg::res_t data_o
);

  localparam int MW = qrv_pkg::Mul2W;
  localparam int RW = qrv_pkg::RW;

  logic signed [qrv_pkg::PW-1:0]    px, py, pz, pw;
  logic signed [qrv_pkg::QuatW-1:0] x, y, z, w;
  logic signed [MW-1:0] n_d [12];
  logic signed [MW-1:0] n_q [12];
  logic                 v3_q, v4_q;
  qrv_pkg::res_t        r_d, r_q;

  assign px = data_i.px;
  assign py = data_i.py;
  assign pz = data_i.pz;
  assign pw = data_i.pw;
  assign x  = data_i.q.x;
  assign y  = data_i.q.y;
  assign z  = data_i.q.z;
  assign w  = data_i.q.w;

  always_comb begin
    n_d[0]  = MW'(pw * x);
    n_d[1]  = MW'(px * w);
    n_d[2]  = MW'(py * z);
    n_d[3]  = MW'(pz * y);
    n_d[4]  = MW'(pw * y);
    n_d[5]  = MW'(px * z);
    n_d[6]  = MW'(py * w);
    n_d[7]  = MW'(pz * x);
    n_d[8]  = MW'(pw * z);
    n_d[9]  = MW'(px * y);
    n_d[10] = MW'(py * x);
    n_d[11] = MW'(pz * w);
  end

  always_comb begin
    r_d.rx = -RW'(n_q[0]) + RW'(n_q[1]) - RW'(n_q[2])  + RW'(n_q[3]);
    r_d.ry = -RW'(n_q[4]) + RW'(n_q[5]) + RW'(n_q[6])  - RW'(n_q[7]);
    r_d.rz = -RW'(n_q[8]) - RW'(n_q[9]) + RW'(n_q[10]) + RW'(n_q[11]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign valid_o = v4_q;
  assign data_o  = r_q;

endmodule

FILE: rtl/core/qrv_round_sat.sv
// Round to nearest (ties up), scale down by 2^(2*QUAT_FRAC_BITS), saturate.
// Holds the output register. Depends on qrv_pkg.
module qrv_round_sat #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  qrv_pkg::res_t data_i,
  output logic          valid_o,
  output qrv_pkg::out_t data_o
);

  localparam int S  = 2 * QUAT_FRAC_BITS;
  localparam int RW = qrv_pkg::RW;
  localparam int VW = qrv_pkg::VecW;
  localparam int AW = ((S > RW) ? S : RW) + 2;
  localparam logic signed [AW-1:0] Half = AW'(1) << (S - 1);
  localparam logic signed [AW-1:0] VMax = AW'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] VMin = -VMax - AW'(1);

  // {sat, value}
  function automatic logic [VW:0] rnd_sat(input logic signed [RW-1:0] r);
    logic signed [AW-1:0] sum;
    logic signed [AW-1:0] sh;
    logic [VW:0]          res;
    sum = AW'(r) + Half;
    sh  = sum >>> S;
    if (sh > VMax) begin
      res = {1'b1, VMax[VW-1:0]};
    end else if (sh < VMin) begin
      res = {1'b1, VMin[VW-1:0]};
    end else begin
      res = {1'b0, sh[VW-1:0]};
    end
    return res;
  endfunction

  logic [VW:0]   sx, sy, sz;
  qrv_pkg::out_t o_d, o_q;
  logic          v5_q;

  always_comb begin
    sx = rnd_sat(data_i.rx);
    sy = rnd_sat(data_i.ry);
    sz = rnd_sat(data_i.rz);
    o_d.rot_x     = sx[VW-1:0];
    o_d.rot_y     = sy[VW-1:0];
    o_d.rot_z     = sz[VW-1:0];
    o_d.saturated = sx[VW] | sy[VW] | sz[VW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_q <= o_d;
    end
  end

  assign valid_o = v5_q;
  assign data_o  = o_q;

endmodule

FILE: rtl/core/quaternion_rotate_vector.sv
// Quaternion vector rotation, q * (v,0) * conj(q), fixed point.
// Top level; depends on qrv_pkg, qrv_skid, qrv_qv_mul, qrv_pq_mul, qrv_round_sat.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one quaternion
// (signed Q1.QUAT_FRAC_BITS) and one signed vector per transfer. Output
// channel out_valid_o / out_stall_i / out_data_o returns the rotated vector,
// rounded to nearest and saturated, with a flag when any part clamped.
// A non-unit quaternion also scales the vector by |q|^2.
// An input transfer passes the product, sum, product, sum and round/saturate
// registers in order. Throughput: one transfer per cycle while out_stall_i is low,
// set by the five-stage multiply/add pipeline (two product stages, two sum
// stages, one round/saturate output register) with no feedback. A receiver
// stall with out_valid_o high freezes the whole pipeline; a one-entry skid
// register absorbs a transfer in flight, so in_stall_o is registered and
// rises in the cycle after the output stalls with a transfer offered. Nothing is lost or repeated.
// Reset (rst_ni low, async) empties all stages and the skid register; no
// other state exists.
module quaternion_rotate_vector #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  qrv_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output qrv_pkg::out_t out_data_o
);

  localparam logic signed [qrv_pkg::VecW-1:0] RotMax = {1'b0, {(qrv_pkg::VecW-1){1'b1}}};
  localparam logic signed [qrv_pkg::VecW-1:0] RotMin = {1'b1, {(qrv_pkg::VecW-1){1'b0}}};

  logic          adv;
  logic          s0_valid, s2_valid, s4_valid, skid_full;
  qrv_pkg::in_t  s0_data;
  qrv_pkg::qv_t  s2_data;
  qrv_pkg::res_t s4_data;

  assign adv = !out_valid_o || !out_stall_i;

  qrv_skid u_skid (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .adv_i   (adv),
    .valid_o (s0_valid),
    .data_o  (s0_data),
    .full_o  (skid_full)
  );

  qrv_qv_mul u_qv_mul (
    .clk_i,
    .rst_ni,
    .en_i    (adv),
    .valid_i (s0_valid),
    .data_i  (s0_data),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  qrv_pq_mul u_pq_mul (
    .clk_i,
    .rst_ni,
    .en_i    (adv),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .valid_o (s4_valid),
    .data_o  (s4_data)
  );

  qrv_round_sat #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_round_sat (
    .clk_i,
    .rst_ni,
    .en_i    (adv),
    .valid_i (s4_valid),
    .data_i  (s4_data),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // skid only fills while the pipeline is frozen
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full) |-> $past(!adv) && $past(in_valid_i))
    else $error("skid register filled without a stalled pipeline");

  // skid drains as soon as the pipeline moves
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full && adv |=> !skid_full)
    else $error("skid register not drained on advance");

  // saturation flag implies at least one clamped component
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.rot_x == RotMax || out_data_o.rot_x == RotMin ||
      out_data_o.rot_y == RotMax || out_data_o.rot_y == RotMin ||
      out_data_o.rot_z == RotMax || out_data_o.rot_z == RotMin)
    else $error("saturated set with no component at a bound");

endmodule

FILE: tb/tb_quaternion_rotate_vector.sv
`timescale 1ns / 100ps
// Self-checking testbench for quaternion_rotate_vector: directed and random rotations,
// predicted exactly in 64-bit integers and checked per transfer. Depends on qrv_pkg and quaternion_rotate_vector.
module tb_quaternion_rotate_vector;

  localparam int  CycleLimit = 200000;
  localparam int  QuietTail  = 150;
  localparam int  HoldAt     = 300;
  localparam int  HoldLen    = 80;
  localparam int  MaxReports = 10;
  localparam longint RoundHalf = 64'sd1 <<< 27;
  localparam longint VecMax    = 64'sd32767;
  localparam longint VecMin    = -64'sd32768;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  qrv_pkg::in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  qrv_pkg::out_t out_data_o;

  qrv_pkg::in_t  pending_q[$];
  qrv_pkg::out_t rotation_expect_q[$];
  int   total_items = 0;
  int   sent = 0;
  int   received = 0;
  int   mismatches = 0;
  int   cycles = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  logic hold_active = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;

  quaternion_rotate_vector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  function automatic logic [15:0] clamp_vec(input longint v, inout logic sat);
    if (v > VecMax) begin
      sat = 1'b1;
      return 16'h7fff;
    end else if (v < VecMin) begin
      sat = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // exact q * (v,0) * conj(q), rounded half up by 2^28
  function automatic qrv_pkg::out_t predict_rotation(input qrv_pkg::in_t d);
    longint x, y, z, w, vx, vy, vz;
    longint px, py, pz, pw, rx, ry, rz;
    logic   sat;
    qrv_pkg::out_t r;
    x  = $signed(d.quat_x);
    y  = $signed(d.quat_y);
    z  = $signed(d.quat_z);
    w  = $signed(d.quat_w);
    vx = $signed(d.vec_x);
    vy = $signed(d.vec_y);
    vz = $signed(d.vec_z);
    px = w * vx + y * vz - z * vy;
    py = w * vy - x * vz + z * vx;
    pz = w * vz + x * vy - y * vx;
    pw = -x * vx - y * vy - z * vz;
    rx = -pw * x + px * w - py * z + pz * y;
    ry = -pw * y + px * z + py * w - pz * x;
    rz = -pw * z - px * y + py * x + pz * w;
    sat = 1'b0;
    r.rot_x = clamp_vec((rx + RoundHalf) >>> 28, sat);
    r.rot_y = clamp_vec((ry + RoundHalf) >>> 28, sat);
    r.rot_z = clamp_vec((rz + RoundHalf) >>> 28, sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic add_item(input int x, input int y, input int z, input int w,
                          input int vx, input int vy, input int vz);
    qrv_pkg::in_t d;
    d.quat_x = 16'(x);
    d.quat_y = 16'(y);
    d.quat_z = 16'(z);
    d.quat_w = 16'(w);
    d.vec_x  = 16'(vx);
    d.vec_y  = 16'(vy);
    d.vec_z  = 16'(vz);
    pending_q.push_back(d);
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0001;
      5: return 16'h4000;
      6: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("quaternion_rotate_vector regression: fail");
      $finish;
    end
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left   <= 0;
      sent       <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rotation_expect_q.push_back(predict_rotation(in_data_i));
        sent <= sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_q.pop_front();
          if (pending_q.size() > QuietTail && ((sent / 128) % 4) != 3 &&
              $urandom_range(0, 7) == 0) begin
            gap_left <= $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_active <= 1'b0;
      hold_done   <= 1'b0;
      hold_cnt    <= 0;
    end else if (!hold_done && !hold_active && received >= HoldAt) begin
      hold_active <= 1'b1;
      hold_cnt    <= 0;
    end else if (hold_active) begin
      if (hold_cnt == HoldLen - 1) begin
        hold_active <= 1'b0;
        hold_done   <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    qrv_pkg::out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      received    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        received <= received + 1;
        if (rotation_expect_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MaxReports) begin
            $display("unexpected transfer: got x=%0d y=%0d z=%0d sat=%0b",
                     out_data_o.rot_x, out_data_o.rot_y, out_data_o.rot_z,
                     out_data_o.saturated);
          end
        end else begin
          want = rotation_expect_q.pop_front();
          if (want.rot_x !== out_data_o.rot_x || want.rot_y !== out_data_o.rot_y ||
              want.rot_z !== out_data_o.rot_z ||
              want.saturated !== out_data_o.saturated) begin
            mismatches <= mismatches + 1;
            if (mismatches < MaxReports) begin
              $display("mismatch at transfer %0d: exp x=%0d y=%0d z=%0d sat=%0b",
                       received, want.rot_x, want.rot_y, want.rot_z, want.saturated);
              $display("                         got x=%0d y=%0d z=%0d sat=%0b",
                       out_data_o.rot_x, out_data_o.rot_y, out_data_o.rot_z,
                       out_data_o.saturated);
            end
          end
        end
      end
      if (hold_active) begin
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (received < total_items - QuietTail && ((received / 100) % 3) != 2 &&
                   $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 5);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    real a[4];
    real norm;
    qrv_pkg::in_t d;
    int  kind;

    // identity, zero and axis rotations
    add_item(0, 0, 0, 16384, 1000, -2000, 3000);
    add_item(0, 0, 0, 16384, 32767, -32768, 0);
    add_item(0, 0, 0, 16384, 0, 0, 0);
    add_item(0, 0, 0, 0, 32767, 32767, -32768);
    add_item(11585, 0, 0, 11585, 100, 200, 300);
    add_item(0, 11585, 0, 11585, 100, 200, 300);
    add_item(0, 0, 11585, 11585, 100, 200, 300);
    add_item(0, 0, 16384, 0, 1234, -5678, 91);
    add_item(16384, 0, 0, 0, -32768, 32767, -1);
    add_item(8192, 8192, 8192, 8192, 32767, 0, -32768);
    add_item(-8192, 8192, -8192, 8192, -1, 1, -1);
    // half-way rounding: +0.5, -0.5, +1.5, -1.5 and either side of +0.5
    add_item(0, 0, 0, 128, 8192, -8192, 24576);
    add_item(0, 0, 0, -128, -24576, 8191, 8193);
    // non-unit scaling and saturation both ways
    add_item(0, 0, 0, 23170, 20000, -20000, 5);
    add_item(0, 0, 0, -32768, 32767, -32768, 1);
    add_item(16384, 16384, 16384, 16384, 16384, -16384, 1);
    add_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_item(32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_item(1, -1, 1, -1, 32767, -32768, 32767);
    add_item(-1, -1, -1, -1, -1, -1, -1);

    repeat (1400) begin
      kind = $urandom_range(0, 99);
      d.vec_x = 16'($urandom);
      d.vec_y = 16'($urandom);
      d.vec_z = 16'($urandom);
      if (kind < 40) begin
        d.quat_x = 16'($urandom);
        d.quat_y = 16'($urandom);
        d.quat_z = 16'($urandom);
        d.quat_w = 16'($urandom);
      end else if (kind < 80) begin
        norm = 0.0;
        while (norm < 0.1) begin
          for (int i = 0; i < 4; i++) begin
            a[i] = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
          end
          norm = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
        end
        d.quat_x = 16'($rtoi(a[0] / norm * 16384.0));
        d.quat_y = 16'($rtoi(a[1] / norm * 16384.0));
        d.quat_z = 16'($rtoi(a[2] / norm * 16384.0));
        d.quat_w = 16'($rtoi(a[3] / norm * 16384.0));
        if ($urandom_range(0, 3) == 0) begin
          d.vec_x = 16'($signed(d.vec_x) >>> $urandom_range(0, 12));
          d.vec_y = 16'($signed(d.vec_y) >>> $urandom_range(0, 12));
          d.vec_z = 16'($signed(d.vec_z) >>> $urandom_range(0, 12));
        end
      end else begin
        d.quat_x = edge_value();
        d.quat_y = edge_value();
        d.quat_z = edge_value();
        d.quat_w = edge_value();
        d.vec_x  = edge_value();
        d.vec_y  = edge_value();
        d.vec_z  = edge_value();
      end
      pending_q.push_back(d);
    end
    total_items = pending_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(sent == total_items && rotation_expect_q.size() == 0)) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("quaternion_rotate_vector regression: pass");
    end else begin
      $display("quaternion_rotate_vector regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/qrv_pkg.sv
rtl/core/qrv_skid.sv
rtl/core/qrv_qv_mul.sv
rtl/core/qrv_pq_mul.sv
rtl/core/qrv_round_sat.sv
rtl/core/quaternion_rotate_vector.sv
tb/tb_quaternion_rotate_vector.sv
